### rtl/dym_pkg.sv
package dym_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned DayW    = 9;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DomW    = 5;
  localparam int unsigned NumMonths = 12;

  // Multiplicative inverse of 25 mod 2^14: y is a multiple of 25 iff
  // (y * inv) mod 2^14 <= floor((2^14 - 1) / 25).
  localparam logic [YearW-1:0] Div25Inv = 14'd7209;
  localparam logic [YearW-1:0] Div25Max = 14'd655;

  localparam logic [DayW-1:0] CommonYearLen = 9'd365;
  localparam logic [DayW-1:0] LeapYearLen   = 9'd366;

  localparam logic [DomW-1:0] FebCommon = 5'd28;
  localparam logic [DomW-1:0] FebLeap   = 5'd29;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [DayW-1:0]  ordinal_day;
  } dym_in_t;

  typedef struct packed {
    logic [MonthW-1:0] month;
    logic [DomW-1:0]   day_of_month;
    logic              leap;
    logic              bad_day;
  } dym_out_t;

  // Data handed from cell to cell.
  typedef struct packed {
    logic [DayW-1:0]   rem;
    logic [MonthW-1:0] mon;
    logic              done;
    logic              leap;
    logic              bad;
  } dym_stage_t;

  // Length of month idx (0 = January).
  function automatic logic [DomW-1:0] month_len(input logic [MonthW-1:0] idx,
                                                input logic leap);
    logic [DomW-1:0] len;
    case (idx)
      4'd1:    len = leap ? FebLeap : FebCommon;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### rtl/dym_front.sv
module dym_front
  import dym_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dym_in_t    in_data_i,
  input  logic       ready_i,
  output logic       ready_o,
  output logic       out_valid_o,
  output dym_stage_t out_stage_o
);

  logic             valid_q;
  dym_stage_t       stage_q, stage_d;
  logic [YearW-1:0] inv_prod;
  logic             div25, leap;
  logic [DayW-1:0]  year_len;
  logic             bad;

  assign inv_prod = in_data_i.year * Div25Inv;
  assign div25    = (inv_prod <= Div25Max);
  // div by 4 and not 100, or div by 400 (= div by 16 and 25)
  assign leap     = ((in_data_i.year[1:0] == 2'd0) && !div25) ||
                    ((in_data_i.year[3:0] == 4'd0) && div25);
  assign year_len = leap ? LeapYearLen : CommonYearLen;
  assign bad      = (in_data_i.ordinal_day == '0) ||
                    (in_data_i.ordinal_day > year_len);

  always_comb begin
    stage_d.rem  = bad ? '0 : in_data_i.ordinal_day;
    stage_d.mon  = '0;
    stage_d.done = bad;
    stage_d.leap = leap;
    stage_d.bad  = bad;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && in_valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_stage_o = stage_q;

endmodule

### rtl/dym_cell.sv
module dym_cell
  import dym_pkg::*;
#(
  parameter int unsigned MonthIdx = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dym_stage_t in_stage_i,
  input  logic       ready_i,
  output logic       ready_o,
  output logic       out_valid_o,
  output dym_stage_t out_stage_o
);

  localparam logic [MonthW-1:0] MonIdx = MonthW'(MonthIdx);
  localparam logic [MonthW-1:0] MonNum = MonthW'(MonthIdx + 1);

  logic            valid_q;
  dym_stage_t      stage_q, stage_d;
  logic [DayW-1:0] len;

  assign len = {{(DayW-DomW){1'b0}}, month_len(MonIdx, in_stage_i.leap)};

  always_comb begin
    stage_d = in_stage_i;
    if (!in_stage_i.done) begin
      if (in_stage_i.rem > len) begin
        stage_d.rem = in_stage_i.rem - len;
      end else begin
        stage_d.done = 1'b1;
        stage_d.mon  = MonNum;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && in_valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_stage_o = stage_q;

endmodule

### rtl/day_of_year_to_month_day.sv
// Gregorian ordinal date to month and day of month.
//
// Input channel: in_valid_i / in_stall_o carry one transaction of year and
// ordinal_day. Output channel: out_valid_o / out_stall_i carry month,
// day_of_month, leap and bad_day. A transaction moves on a rising edge
// with valid high and stall low.
//
// Structure: one front stage (leap decision, range check) followed by a
// row of twelve month cells, one per month; each cell either takes its
// month's length off the remaining day count or marks the date resolved.
// The last cell's register drives the output.
//
// Depth: 13 register stages, the front stage followed by the twelve cells.
// Throughput: one transaction per cycle, sustained while out_stall_i is low.
// Stall: out_stall_i holds the last cell; bubbles in the row are filled
// first, and in_stall_o rises only when every stage holds data.
// Reset empties all stages; no results are pending after reset.
module day_of_year_to_month_day
  import dym_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dym_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dym_out_t out_data_o
);

  logic       vld [NumMonths+1];
  dym_stage_t stg [NumMonths+1];
  logic       rdy [NumMonths+2];

  assign rdy[NumMonths+1] = !out_stall_i;
  assign in_stall_o       = !rdy[0];

  dym_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .ready_i     (rdy[1]),
    .ready_o     (rdy[0]),
    .out_valid_o (vld[0]),
    .out_stage_o (stg[0])
  );

  for (genvar i = 0; i < NumMonths; i++) begin : g_cell
    dym_cell #(
      .MonthIdx (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[i]),
      .in_stage_i  (stg[i]),
      .ready_i     (rdy[i+2]),
      .ready_o     (rdy[i+1]),
      .out_valid_o (vld[i+1]),
      .out_stage_o (stg[i+1])
    );
  end

  assign out_valid_o             = vld[NumMonths];
  assign out_data_o.month        = stg[NumMonths].mon;
  assign out_data_o.day_of_month = stg[NumMonths].rem[DomW-1:0];
  assign out_data_o.leap         = stg[NumMonths].leap;
  assign out_data_o.bad_day      = stg[NumMonths].bad;

endmodule

### rtl/dym_checker.sv
module dym_checker
  import dym_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input dym_out_t out_data_o
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_day |->
      out_data_o.month == '0 && out_data_o.day_of_month == '0)
    else $error("bad day with nonzero month or day");

  a_good_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.bad_day |->
      out_data_o.month != '0 && out_data_o.month <= 4'd12 &&
      out_data_o.day_of_month != '0)
    else $error("valid date out of range");

  a_feb_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.month == 4'd2 |->
      out_data_o.day_of_month <= (out_data_o.leap ? FebLeap : FebCommon))
    else $error("February day too large");

  // stall toward the sender only when the output side is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

bind day_of_year_to_month_day dym_checker u_dym_checker (.*);
